// ===== rtl/diff_drive_odometry_macros.svh =====
// assertion macros shared by the odometry rtl
// no dependencies
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH
// property that holds from reset release on
`define DDO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked even during reset
`define DDO_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/ddo_pkg.sv =====
// package for the odometry block: formats, constants, cordic arctangent table
// no dependencies
`default_nettype none
package ddo_pkg;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CORDIC_MAX       = 32;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam logic [31:0] RAD_TO_BAM  = 32'd683565276;
    localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;    5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
                5'd20: r = 32'd652;        5'd21: r = 32'd326;
                5'd22: r = 32'd163;        5'd23: r = 32'd81;
                5'd24: r = 32'd41;         5'd25: r = 32'd20;
                5'd26: r = 32'd10;         5'd27: r = 32'd5;
                5'd28: r = 32'd3;          5'd29: r = 32'd1;
                5'd30: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    typedef enum logic [3:0] {
        S_IDLE, S_MULV, S_MULW, S_COR1, S_PX, S_PY, S_DH, S_HEAD, S_COR2, S_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        logic [31:0] angle;
    } t_cor_req;

    typedef struct packed {
        logic done;
        logic busy;
    } t_cor_stat;
endpackage
`default_nettype wire

// ===== rtl/ddo_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation a cycle
// depends on ddo_pkg, diff_drive_odometry_macros.svh
`default_nettype none
`include "diff_drive_odometry_macros.svh"
module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire ddo_pkg::t_cor_req  i_req,
    output ddo_pkg::t_cor_stat      o_stat,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin
);
    localparam int NSTEP = (CORDIC_STEPS > ddo_pkg::CORDIC_MAX) ?
                           ddo_pkg::CORDIC_MAX : CORDIC_STEPS;

    logic               r_busy, r_done;
    logic [5:0]         r_i;
    logic signed [35:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic [1:0]         r_q;
    logic signed [35:0] dx, dy, cx, sx;
    logic [1:0]         q;
    logic [31:0]        rem, at;

    assign q   = 2'((i_req.angle + 32'h2000_0000) >> 30);
    assign rem = i_req.angle - {q, 30'd0};
    assign dx  = r_y >>> r_i[4:0];
    assign dy  = r_x >>> r_i[4:0];
    assign at  = ddo_pkg::atan_bam(r_i[4:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= 36'(ddo_pkg::CORDIC_GAIN);
                r_y    <= '0;
                r_z    <= 33'(signed'(rem));
                r_q    <= q;
            end else if (r_busy) begin
                if (!r_z[32]) begin
                    r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - 33'(at);
                end else begin
                    r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + 33'(at);
                end
                r_i <= r_i + 6'd1;
                if (r_i == 6'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (r_q)
            2'd0: begin cx = r_x;  sx = r_y;  end
            2'd1: begin cx = -r_y; sx = r_x;  end
            2'd2: begin cx = -r_x; sx = -r_y; end
            default: begin cx = r_y; sx = -r_x; end
        endcase
        if (cx > ddo_pkg::ONE_Q30) cx = ddo_pkg::ONE_Q30;
        if (cx < -ddo_pkg::ONE_Q30) cx = -ddo_pkg::ONE_Q30;
        if (sx > ddo_pkg::ONE_Q30) sx = ddo_pkg::ONE_Q30;
        if (sx < -ddo_pkg::ONE_Q30) sx = -ddo_pkg::ONE_Q30;
    end

    assign o_cos       = 32'(cx);
    assign o_sin       = 32'(sx);
    assign o_stat.done = r_done;
    assign o_stat.busy = r_busy;

    `DDO_ASSERT(a_cor_done_once, i_clk, i_rst_n, r_done |=> !r_done, "cordic done held")
    `DDO_ASSERT(a_cor_done_busy, i_clk, i_rst_n, r_done |-> !r_busy, "done while busy")
    `DDO_ASSERT(a_cor_idx, i_clk, i_rst_n, r_busy |-> r_i < 6'(NSTEP), "step index overrun")
endmodule
`default_nettype wire

// ===== rtl/diff_drive_odometry.sv =====
// odometry top level: sequencer, shared 32x32 multiplier, pose state
// depends on ddo_pkg, ddo_cordic, diff_drive_odometry_macros.svh
// a new tick is taken only once the last pose is handed over; not ready while working
// the cordic iterations dominate the time per tick; one multiplier serves all products, the 64-bit ones in two halves
// reset (synchronous, active low) clears x, y, heading and the sequencer
`default_nettype none
`include "diff_drive_odometry_macros.svh"
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [95:0]  s_axis_tdata,   // lin_vel, ang_vel, elapsed
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [223:0] m_axis_tdata    // pos_x_out, pos_y_out, yaw_angle, quat_z, quat_w
);
    ddo_pkg::t_state r_st, n_st;
    ddo_pkg::t_cor_req  cor_req;
    ddo_pkg::t_cor_stat cor_stat;
    logic signed [31:0] cos_v, sin_v;

    logic [63:0] r_px, r_py;
    logic [32:0] r_head;
    logic [31:0] r_vmag, r_wmag, r_dt;
    logic        r_vneg, r_wneg;
    logic [63:0] r_vp, r_wp;      // exact speed*dt products
    logic signed [31:0] r_c, r_s;
    logic [31:0] r_qz, r_qw;
    logic        r_half;          // which 32-bit half of the 64-bit operand
    logic [63:0] r_lo;            // low partial product
    logic        r_neg;

    // shared multiplier: 32 x 32 unsigned, one per cycle
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // trig operand of current step
    logic signed [31:0] trig;
    logic [31:0]        tmag;
    assign trig = (r_st == ddo_pkg::S_PY) ? r_s : r_c;
    assign tmag = trig[31] ? 32'(-trig) : trig;

    // half-up rounding: add half an lsb of the result before the shift
    logic [63:0] sum_t, mag38, mag40;
    assign sum_t = mul_p + {32'd0, r_lo[63:32]};
    assign mag38 = (sum_t + 64'd32) >> 6;
    assign mag40 = (sum_t + 64'd128) >> 8;

    // sequencer is waiting on the cordic
    logic cor_wait_st;
    assign cor_wait_st = (r_st == ddo_pkg::S_COR1) || (r_st == ddo_pkg::S_COR2);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_st)
            ddo_pkg::S_MULV: begin mul_a = r_vmag; mul_b = r_dt; end
            ddo_pkg::S_MULW: begin mul_a = r_wmag; mul_b = r_dt; end
            ddo_pkg::S_PX, ddo_pkg::S_PY: begin
                mul_a = r_half ? r_vp[63:32] : r_vp[31:0];
                mul_b = tmag;
            end
            ddo_pkg::S_DH: begin
                mul_a = r_half ? r_wp[63:32] : r_wp[31:0];
                mul_b = ddo_pkg::RAD_TO_BAM;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ddo_pkg::S_IDLE: if (s_axis_tvalid) n_st = ddo_pkg::S_MULV;
            ddo_pkg::S_MULV: n_st = ddo_pkg::S_MULW;
            ddo_pkg::S_MULW: n_st = ddo_pkg::S_COR1;
            ddo_pkg::S_COR1: if (cor_stat.done) n_st = ddo_pkg::S_PX;
            ddo_pkg::S_PX:   if (r_half) n_st = ddo_pkg::S_PY;
            ddo_pkg::S_PY:   if (r_half) n_st = ddo_pkg::S_DH;
            ddo_pkg::S_DH:   if (r_half) n_st = ddo_pkg::S_HEAD;
            ddo_pkg::S_HEAD: n_st = ddo_pkg::S_COR2;
            ddo_pkg::S_COR2: if (cor_stat.done) n_st = ddo_pkg::S_OUT;
            ddo_pkg::S_OUT:  if (m_axis_tready) n_st = ddo_pkg::S_IDLE;
            default:         n_st = ddo_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = (r_st == ddo_pkg::S_IDLE);
        m_axis_tvalid = (r_st == ddo_pkg::S_OUT);
        cor_req.start = (r_st == ddo_pkg::S_MULW) || (r_st == ddo_pkg::S_HEAD);
        cor_req.angle = (r_st == ddo_pkg::S_HEAD) ? r_head[32:1] : r_head[31:0];
    end

    ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_stat  (cor_stat),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ddo_pkg::S_IDLE;
            r_px   <= '0;
            r_py   <= '0;
            r_head <= '0;
            r_half <= 1'b0;
        end else begin
            r_st <= n_st;
            case (r_st)
                ddo_pkg::S_IDLE: if (s_axis_tvalid) begin
                    r_vneg <= s_axis_tdata[31];
                    r_vmag <= s_axis_tdata[31] ? 32'(-s_axis_tdata[31:0])
                                               : s_axis_tdata[31:0];
                    r_wneg <= s_axis_tdata[63];
                    r_wmag <= s_axis_tdata[63] ? 32'(-s_axis_tdata[63:32])
                                               : s_axis_tdata[63:32];
                    r_dt   <= s_axis_tdata[95:64];
                    r_half <= 1'b0;
                end
                ddo_pkg::S_MULV: r_vp <= mul_p;
                ddo_pkg::S_MULW: r_wp <= mul_p;
                ddo_pkg::S_COR1: if (cor_stat.done) begin
                    r_c <= cos_v;
                    r_s <= sin_v;
                end
                ddo_pkg::S_PX, ddo_pkg::S_PY: begin
                    r_half <= !r_half;
                    if (!r_half) begin
                        r_lo  <= mul_p;
                        r_neg <= r_vneg ^ trig[31];
                    end else if (r_st == ddo_pkg::S_PX) begin
                        r_px <= r_px + (r_neg ? 64'(-mag38) : mag38);
                    end else begin
                        r_py <= r_py + (r_neg ? 64'(-mag38) : mag38);
                    end
                end
                ddo_pkg::S_DH: begin
                    r_half <= !r_half;
                    if (!r_half) r_lo <= mul_p;
                    else r_head <= r_head + 33'(r_wneg ? 64'(-mag40) : mag40);
                end
                ddo_pkg::S_COR2: if (cor_stat.done) begin
                    r_qw <= cos_v;
                    r_qz <= sin_v;
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tdata = {r_qw, r_qz, r_head[31:0], r_py, r_px};

    `DDO_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> r_st == ddo_pkg::S_IDLE, "reset not idle")
    `DDO_ASSERT(a_excl, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid), "ready while output")
    `DDO_ASSERT(a_cor_wait, i_clk, i_rst_n, cor_stat.done |-> cor_wait_st, "cordic done out of step")
endmodule
`default_nettype wire

// ===== test/tb_diff_drive_odometry_chk.sv =====
// checker for the odometry block: watches both stream channels, predicts each pose
// depends on nothing but the port widths of diff_drive_odometry
`timescale 1ns / 1ps
module tb_diff_drive_odometry_chk #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    input  wire          i_in_ready,
    input  wire  [95:0]  i_in_data,
    input  wire          i_out_valid,
    input  wire          i_out_ready,
    input  wire  [223:0] i_out_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_pose_count
);
    // packed from the top bits down, so pos_x lands in the lowest bits
    typedef struct packed {
        logic [31:0] qw;
        logic [31:0] qz;
        logic [31:0] yaw;
        logic [63:0] py;
        logic [63:0] px;
    } t_pose;

    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
    localparam logic [63:0] GAIN_Q30 = 64'd652032874;
    localparam logic [63:0] BAM_PER_RAD = 64'd683565276;

    logic [31:0] arctan_bam [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    logic [63:0] track_x, track_y;
    logic [32:0] track_heading;
    t_pose       pose_queue [$];

    // round(m * c / 2^s), half up, done in wide arithmetic
    function automatic logic [63:0] scale_round(logic [63:0] m, logic [63:0] c, int s);
        logic [127:0] p;
        p = {64'd0, m} * {64'd0, c};
        p = p + (128'd1 << (s - 1));
        p = p >> s;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] clip_q30(logic signed [63:0] v);
        if (v > Q30_ONE) return Q30_ONE;
        if (v < -Q30_ONE) return -Q30_ONE;
        return v;
    endfunction

    task automatic cordic_sincos(input logic [31:0] ang,
                                 output logic signed [63:0] co,
                                 output logic signed [63:0] si);
        logic [31:0] quad, rem;
        logic signed [63:0] x, y, z, dx, dy;
        int n;
        quad = (ang + 32'h2000_0000) >> 30;
        rem = ang - (quad << 30);
        z = {{32{rem[31]}}, rem};
        x = GAIN_Q30;
        y = 0;
        n = CORDIC_STEPS > 32 ? 32 : CORDIC_STEPS;
        for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - $signed({32'd0, arctan_bam[i]});
            end else begin
                x = x + dx; y = y - dy; z = z + $signed({32'd0, arctan_bam[i]});
            end
        end
        case (quad[1:0])
            2'd0: begin co = x;  si = y;  end
            2'd1: begin co = -y; si = x;  end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
        endcase
        co = clip_q30(co);
        si = clip_q30(si);
    endtask

    // displacement along one axis, sign applied after the rounded magnitude
    function automatic logic [63:0] axis_step(logic [63:0] prod, logic neg,
                                              logic signed [63:0] trig);
        logic [63:0] mag;
        if (trig < 0) begin
            neg = !neg;
            trig = -trig;
        end
        mag = scale_round(prod, trig, 38);
        return neg ? -mag : mag;
    endfunction

    task automatic advance_pose(input logic [95:0] beat, output t_pose p);
        logic [31:0] lin, ang;
        logic [63:0] vmag, wmag, dt, dh;
        logic signed [63:0] c, s, qz, qw;
        lin = beat[31:0];
        ang = beat[63:32];
        dt = {32'd0, beat[95:64]};
        vmag = lin[31] ? (64'h1_0000_0000 - lin) : {32'd0, lin};
        wmag = ang[31] ? (64'h1_0000_0000 - ang) : {32'd0, ang};
        // position moves along the old heading
        cordic_sincos(track_heading[31:0], c, s);
        track_x = track_x + axis_step(vmag * dt, lin[31], c);
        track_y = track_y + axis_step(vmag * dt, lin[31], s);
        dh = scale_round(wmag * dt, BAM_PER_RAD, 40);
        if (ang[31]) dh = -dh;
        track_heading = track_heading + dh[32:0];
        // half angle for the quaternion, odd lsb dropped
        cordic_sincos(track_heading[32:1], qw, qz);
        p.px = track_x;
        p.py = track_y;
        p.yaw = track_heading[31:0];
        p.qz = qz[31:0];
        p.qw = qw[31:0];
    endtask

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch on pose %0d, %s: expected %h, got %h",
                     o_pose_count, field, want, got);
    endtask

    assign o_pending = pose_queue.size();

    always @(posedge i_clk) begin
        t_pose want, got;
        if (!i_rst_n) begin
            track_x = '0;
            track_y = '0;
            track_heading = '0;
            pose_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                advance_pose(i_in_data, want);
                pose_queue.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pose_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("pose beat with nothing expected");
                end else begin
                    want = pose_queue.pop_front();
                    if (got.px !== want.px) report("pos_x", want.px, got.px);
                    if (got.py !== want.py) report("pos_y", want.py, got.py);
                    if (got.yaw !== want.yaw) report("yaw", want.yaw, got.yaw);
                    if (got.qz !== want.qz) report("quat_z", want.qz, got.qz);
                    if (got.qw !== want.qw) report("quat_w", want.qw, got.qw);
                end
                o_pose_count++;
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_pose_count = 0;
    end
endmodule

// ===== test/tb_diff_drive_odometry.sv =====
// testbench top for diff_drive_odometry: clock, reset, tick stimulus and verdict
// depends on the rtl and on tb_diff_drive_odometry_chk
`timescale 1ns / 1ps
module tb_diff_drive_odometry;
    localparam int RANDOM_TICKS = 1230;
    localparam int CYCLE_LIMIT = 1000000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;  // lin_vel, ang_vel, elapsed
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [223:0] m_axis_tdata;       // pos_x_out, pos_y_out, yaw_angle, quat_z, quat_w
    int           fail_count, pending, pose_count;
    int           cycle_count = 0;
    int           tick_count = 0;

    always #1 i_clk = ~i_clk;

    diff_drive_odometry i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    tb_diff_drive_odometry_chk i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_pose_count(pose_count)
    );

    // half the time no gap at all, else mostly short gaps and a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    // receiver stalls at random: any accepting cycle may start a stall of random length
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= gap_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one tick beat; valid stays high into the next tick when no gap follows
    task automatic send_tick(input logic [31:0] lin, input logic [31:0] ang,
                             input logic [31:0] dt);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dt, ang, lin};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tick_count++;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_poses();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // realistic tick: about 20 ms, moderate speeds; else anything the fields hold
    task automatic random_tick();
        logic [31:0] lin, ang, dt;
        if ($urandom_range(0, 9) < 7) begin
            lin = $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            ang = $signed($urandom_range(0, 32'h000c_0000)) - 32'sh0006_0000;
            dt = $urandom_range(32'h0004_0000, 32'h0006_0000);
        end else begin
            lin = $urandom;
            ang = $urandom;
            dt = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
        end
        send_tick(lin, ang, dt);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero time, field extremes, heading wrap, quadrant axes
        send_tick(32'h0001_0000, 32'h0001_0000, 32'd0);
        send_tick(32'h0001_0000, 32'd0, 32'h0100_0000);
        send_tick(32'h7fff_ffff, 32'd0, 32'hffff_ffff);
        send_tick(32'h8000_0000, 32'd0, 32'hffff_ffff);
        send_tick(32'hffff_ffff, 32'hffff_ffff, 32'd1);
        send_tick(32'd0, 32'h7fff_ffff, 32'hffff_ffff);
        send_tick(32'd0, 32'h8000_0000, 32'hffff_ffff);
        send_tick(32'h0001_0000, 32'h0001_921f, 32'h0100_0000);
        send_tick(32'h0001_0000, 32'h0001_921f, 32'h0100_0000);
        send_tick(32'h0001_0000, 32'h0001_921f, 32'h0100_0000);
        send_tick(32'h0001_0000, 32'h0001_921f, 32'h0100_0000);
        send_tick(32'h0001_0000, 32'h0003_243f, 32'h0100_0000);
        send_tick(32'h0001_0000, 32'hfffc_dbc1, 32'h0100_0000);
        send_tick(32'h0001_0000, 32'h0000_c90f, 32'h0100_0000);
        send_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_tick(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_tick(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
        send_tick(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
        send_tick(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_tick(32'hfff0_0000, 32'd0, 32'd0);

        // hold off until every pose is back, then the random run
        drain_poses();
        for (int i = 0; i < RANDOM_TICKS; i++) begin
            random_tick();
            if (i == RANDOM_TICKS / 2) drain_poses();
        end
        drain_poses();
        repeat (100) @(posedge i_clk);

        $display("%0d ticks sent, %0d poses checked, directed extremes plus random motion",
                 tick_count, pose_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d poses outstanding", fail_count, pending);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
